// ----- rtl/spa_pkg.sv -----
// ----------------------------------------------------------------------------
// spa_pkg: shared types and constants of the sparse polynomial accumulator
// Item formats, controller states and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int MAX_TERMS_DEF = 64;
  localparam int COEFF_W       = 32;
  localparam int DEG_W         = 10;

  localparam logic signed [COEFF_W-1:0] COEFF_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
  localparam logic signed [COEFF_W-1:0] COEFF_MIN = {1'b1, {(COEFF_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff_in;
    logic [DEG_W-1:0]          degree_in;
    logic                      negate;
    logic                      final_term;
  } in_item_t;

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff_out;
    logic [DEG_W-1:0]          degree_out;
    logic                      is_zero_poly;
    logic                      overflowed;
    logic                      end_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic search;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic last;
    logic slot_free;
  } sts_t;

endpackage

// ----- rtl/spa_ctrl.sv -----
// ----------------------------------------------------------------------------
// spa_ctrl: sequencing controller
// Steps each item through load, search and update, then runs the emission
// of the table when the item is final.
// ----------------------------------------------------------------------------
module spa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  spa_pkg::sts_t sts,
  output spa_pkg::cmd_t cmd
);

  spa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      spa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = spa_pkg::ST_SEARCH;
        end
      end
      spa_pkg::ST_SEARCH: begin
        cmd.search = 1'b1;
        state_nxt  = spa_pkg::ST_UPDATE;
      end
      spa_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = sts.fin ? spa_pkg::ST_EMIT : spa_pkg::ST_IDLE;
      end
      spa_pkg::ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.last) state_nxt = spa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spa_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/spa_datapath.sv -----
// ----------------------------------------------------------------------------
// spa_datapath: term register chain, saturating adder and output register
// Holds the sorted terms in a chain of registers that shifts for insert,
// delete and emission.
// ----------------------------------------------------------------------------
module spa_datapath #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  spa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spa_pkg::out_item_t out_data,
  input  spa_pkg::cmd_t      cmd,
  output spa_pkg::sts_t      sts
);

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int CW    = spa_pkg::COEFF_W;
  localparam int DW    = spa_pkg::DEG_W;

  logic signed [CW-1:0] coeff_r;
  logic [DW-1:0]        deg_r;
  logic                 fin_r;

  logic [DW-1:0]        deg_r_a   [MAX_TERMS];
  logic signed [CW-1:0] cf_r_a    [MAX_TERMS];
  logic [DW-1:0]        deg_nxt_a [MAX_TERMS];
  logic signed [CW-1:0] cf_nxt_a  [MAX_TERMS];

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;

  logic [MAX_TERMS-1:0] lt_nxt, eq_nxt, lt_r, eq_r;
  logic signed [CW-1:0] match_nxt, match_r;

  logic                 out_valid_r, out_valid_nxt;
  spa_pkg::out_item_t   out_data_r, out_data_nxt;

  logic signed [CW-1:0] neg_coeff;
  logic signed [CW:0]   wide_sum;
  logic signed [CW-1:0] sat_sum;
  logic                 hit;

  // Negation saturates the most negative value.
  always_comb begin
    if (in_data.coeff_in == spa_pkg::COEFF_MIN) begin
      neg_coeff = spa_pkg::COEFF_MAX;
    end else begin
      neg_coeff = -in_data.coeff_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      coeff_r <= in_data.negate ? neg_coeff : in_data.coeff_in;
      deg_r   <= in_data.degree_in;
      fin_r   <= in_data.final_term;
    end
  end

  // Parallel compare of every live entry against the incoming degree.
  always_comb begin
    match_nxt = '0;
    for (int i = 0; i < MAX_TERMS; i++) begin
      lt_nxt[i] = (CNT_W'(i) < count_r) && (deg_r_a[i] < deg_r);
      eq_nxt[i] = (CNT_W'(i) < count_r) && (deg_r_a[i] == deg_r);
      match_nxt = match_nxt | (cf_r_a[i] & {CW{eq_nxt[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      lt_r    <= lt_nxt;
      eq_r    <= eq_nxt;
      match_r <= match_nxt;
    end
  end

  assign hit      = |eq_r;
  assign wide_sum = {match_r[CW-1], match_r} + {coeff_r[CW-1], coeff_r};

  always_comb begin
    if (wide_sum[CW] != wide_sum[CW-1]) begin
      sat_sum = wide_sum[CW] ? spa_pkg::COEFF_MIN : spa_pkg::COEFF_MAX;
    end else begin
      sat_sum = wide_sum[CW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_TERMS; i++) begin
      deg_nxt_a[i] = deg_r_a[i];
      cf_nxt_a[i]  = cf_r_a[i];
    end
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (cmd.update && (coeff_r != '0)) begin
      if (hit) begin
        if (sat_sum == '0) begin
          // Close the gap left by the cancelled term.
          for (int i = 0; i < MAX_TERMS - 1; i++) begin
            if (!lt_r[i]) begin
              deg_nxt_a[i] = deg_r_a[i+1];
              cf_nxt_a[i]  = cf_r_a[i+1];
            end
          end
          count_nxt = count_r - 1'b1;
        end else begin
          for (int i = 0; i < MAX_TERMS; i++) begin
            if (eq_r[i]) cf_nxt_a[i] = sat_sum;
          end
        end
      end else if (count_r == CNT_W'(MAX_TERMS)) begin
        ovf_nxt = 1'b1;
      end else begin
        // Entries at and above the insert point move up by one.
        for (int i = 0; i < MAX_TERMS; i++) begin
          if (!lt_r[i]) begin
            if ((i == 0) || lt_r[(i == 0) ? 0 : i-1]) begin
              deg_nxt_a[i] = deg_r;
              cf_nxt_a[i]  = coeff_r;
            end else begin
              deg_nxt_a[i] = deg_r_a[(i == 0) ? 0 : i-1];
              cf_nxt_a[i]  = cf_r_a[(i == 0) ? 0 : i-1];
            end
          end
        end
        count_nxt = count_r + 1'b1;
      end
    end

    if (cmd.emit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.overflowed = ovf_r;
      if (count_r == '0) begin
        out_data_nxt.coeff_out    = '0;
        out_data_nxt.degree_out   = '0;
        out_data_nxt.is_zero_poly = 1'b1;
        out_data_nxt.end_of_run   = 1'b1;
        ovf_nxt                   = 1'b0;
      end else begin
        // Emission pops the head of the chain.
        out_data_nxt.coeff_out    = cf_r_a[0];
        out_data_nxt.degree_out   = deg_r_a[0];
        out_data_nxt.is_zero_poly = 1'b0;
        out_data_nxt.end_of_run   = (count_r == CNT_W'(1));
        for (int i = 0; i < MAX_TERMS - 1; i++) begin
          deg_nxt_a[i] = deg_r_a[i+1];
          cf_nxt_a[i]  = cf_r_a[i+1];
        end
        count_nxt = count_r - 1'b1;
        if (count_r == CNT_W'(1)) ovf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TERMS; i++) begin
      deg_r_a[i] <= deg_nxt_a[i];
      cf_r_a[i]  <= cf_nxt_a[i];
    end
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.fin       = fin_r;
  assign sts.last      = (count_r <= CNT_W'(1));
  assign sts.slot_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/sparse_polynomial_accumulator.sv -----
// ----------------------------------------------------------------------------
// sparse_polynomial_accumulator: sorted sparse polynomial accumulator
// Adds or subtracts terms into a degree-sorted table with Q16.16 saturating
// coefficients and emits the whole polynomial on a final item.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Ports                      Payload
//   input     in         in_valid / in_ready        in_data  (spa_pkg::in_item_t)
//   result    out        out_valid / out_ready      out_data (spa_pkg::out_item_t)
//
// Each input item steps through accept, a parallel compare of every
// stored degree against the new one, then the saturating add and the shift
// of the term register chain for insert or delete. A final item then emits
// one result per cycle from the head of the chain unless the output stalls,
// and one result when empty. Reset clears the term count, the overflow flag
// and the output valid flag; the term registers need no reset, since only
// live entries are read. A stalled output holds the emission in place, while
// a pending result never blocks the next input item once emission has finished.
//
module sparse_polynomial_accumulator #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spa_pkg::out_item_t out_data
);

  // Command and status groups between the sequencer and the datapath.
  spa_pkg::cmd_t cmd;
  spa_pkg::sts_t sts;

  // The controller owns the input handshake and walks each item through its
  // steps; it issues an emission step only when the output register is free.
  spa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the sorted term chain, the count, the sticky overflow
  // flag and the output register.
  spa_datapath #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
